// ----- rtl/core/spqs_pkg.sv -----
// Shared constants and types for the sine PCM quantizer and serializer.
package spqs_pkg;
    localparam int unsigned SIN_C1 = 51472;
    localparam int unsigned SIN_C3 = 21024;
    localparam int unsigned SIN_C5 = 2320;

    typedef enum logic [2:0] {
        REG_AMPLITUDE    = 3'd0,
        REG_PHASE_STEP   = 3'd1,
        REG_PHASE_OFFSET = 3'd2,
        REG_LEVELS       = 3'd3,
        REG_CODE_BITS    = 3'd4
    } t_reg_idx;
endpackage

// ----- rtl/core/spqs_cell.sv -----
// One pipeline cell: registers a stage result and hands it to the next cell.
module spqs_cell #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  logic [W-1:0] i_data,
    output logic         o_vld,
    output logic [W-1:0] o_data
);
    logic         r_vld;
    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_data <= i_data;
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;
endmodule

// ----- rtl/core/sine_pcm_quantize_serialize_top.sv -----
// Top level: sine source, uniform PCM quantizer and serial encoder.
//
// Usage: pulse i_start with i_time_index while busy is low. The block
// computes a sine sample through a row of pipeline cells (phase multiply,
// x squared, two polynomial steps, final multiply, quantizer multiply) and
// then shifts code_bits serial bits out MSB first, one per cycle, each on
// o_strobe for exactly one cycle, with o_is_last on the final bit and the
// level on o_level_value for every bit.
// busy holds off new requests until the next code word may follow
// (code_bits is clamped to 1..16), so each code word starts as the
// previous one ends and compute and output overlap.
// Configuration: i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data, always
// ready; write only while idle. Reset restores register defaults and drops
// all in-flight work. The receiver cannot stall the output.
module sine_pcm_quantize_serialize_top #(
    parameter int PHASE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        busy,
    input  logic [31:0] i_time_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic        o_bit_value,
    output logic        o_is_last,
    output logic [15:0] o_level_value
);
    localparam int PM = PHASE_BITS;

    logic [14:0] r_amplitude;
    logic [15:0] r_phase_step, r_phase_offset;
    logic [16:0] r_levels;
    logic [4:0]  r_code_bits;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude    <= 15'd16384;
            r_phase_step   <= 16'd256;
            r_phase_offset <= 16'd0;
            r_levels       <= 17'd256;
            r_code_bits    <= 5'd8;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                spqs_pkg::REG_AMPLITUDE:    r_amplitude    <= i_cfg_data[14:0];
                spqs_pkg::REG_PHASE_STEP:   r_phase_step   <= i_cfg_data[15:0];
                spqs_pkg::REG_PHASE_OFFSET: r_phase_offset <= i_cfg_data[15:0];
                spqs_pkg::REG_LEVELS:       r_levels       <= i_cfg_data[16:0];
                spqs_pkg::REG_CODE_BITS:    r_code_bits    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic accept;
    assign accept = i_start && !busy;

    // Stage 0: phase and zero flag
    logic [PM-1:0] ph0;
    logic [PM-1:0] ph_prod;
    logic          zero0;
    assign ph_prod = PM'(32'(r_phase_step) * i_time_index[31:0]);
    assign ph0     = ph_prod + PM'(r_phase_offset);
    assign zero0   = i_time_index[31] || (r_amplitude == 15'd0);

    logic [31:0] p32;
    logic [14:0] x0r;
    logic [15:0] x0;
    assign p32 = 32'(ph0) << (32 - PM);
    assign x0r = p32[29:15];
    assign x0  = p32[30] ? (16'd32768 - {1'b0, x0r}) : {1'b0, x0r};

    localparam int W1 = 16 + 2 + 1;
    logic v1; logic [W1-1:0] d1;
    spqs_cell #(.W(W1)) u_c1 (.i_clk, .i_rst_n, .i_vld(accept),
        .i_data({x0, p32[31:30], zero0}), .o_vld(v1), .o_data(d1));

    // Stage 2: x2
    logic [31:0] sq;
    assign sq = 32'(d1[18:3]) * 32'(d1[18:3]);
    localparam int W2 = 16 + 16 + 3;
    logic v2; logic [W2-1:0] d2;
    spqs_cell #(.W(W2)) u_c2 (.i_clk, .i_rst_n, .i_vld(v1),
        .i_data({sq[30:15], d1[18:0]}), .o_vld(v2), .o_data(d2));

    // Stage 3: t = C3 - (C5*x2 >> 15)
    logic [31:0] m3;
    logic [15:0] t3;
    assign m3 = 32'(spqs_pkg::SIN_C5) * 32'(d2[34:19]);
    assign t3 = 16'(32'(spqs_pkg::SIN_C3) - (m3 >> 15));
    localparam int W3 = 16 + W2;
    logic v3; logic [W3-1:0] d3;
    spqs_cell #(.W(W3)) u_c3 (.i_clk, .i_rst_n, .i_vld(v2),
        .i_data({t3, d2}), .o_vld(v3), .o_data(d3));

    // Stage 4: t = C1 - (t*x2 >> 15)
    logic [31:0] m4;
    logic [15:0] t4;
    assign m4 = 32'(d3[50:35]) * 32'(d3[34:19]);
    assign t4 = 16'(32'(spqs_pkg::SIN_C1) - (m4 >> 15));
    localparam int W4 = 16 + 19;
    logic v4; logic [W4-1:0] d4;
    spqs_cell #(.W(W4)) u_c4 (.i_clk, .i_rst_n, .i_vld(v3),
        .i_data({t4, d3[18:0]}), .o_vld(v4), .o_data(d4));

    // Stage 5: y, clamp, sign, offset to unsigned s+32768
    logic [31:0] m5, y5;
    logic [15:0] yc;
    logic [16:0] u5;
    assign m5 = 32'(d4[34:19]) * 32'(d4[18:3]);
    assign y5 = m5 >> 15;
    assign yc = (y5 > 32'd32767) ? 16'd32767 : y5[15:0];
    always_comb begin
        if (d4[0])       u5 = 17'd32768;
        else if (d4[2])  u5 = 17'd32768 - 17'(yc);
        else             u5 = 17'd32768 + 17'(yc);
    end
    logic v5; logic [16:0] d5;
    spqs_cell #(.W(17)) u_c5 (.i_clk, .i_rst_n, .i_vld(v4),
        .i_data(u5), .o_vld(v5), .o_data(d5));

    // Stage 6: quantize
    logic [16:0] lv;
    logic [33:0] q6;
    logic [17:0] qs;
    logic [15:0] lvl6;
    assign lv = (r_levels > 17'd65536) ? 17'd65536 : r_levels;
    assign q6 = 34'(d5) * 34'(lv);
    assign qs = q6[33:16];
    always_comb begin
        if (lv < 17'd2)                  lvl6 = 16'd0;
        else if (qs > 18'(lv - 17'd1))   lvl6 = 16'(lv - 17'd1);
        else                             lvl6 = qs[15:0];
    end
    logic v6; logic [15:0] d6;
    spqs_cell #(.W(16)) u_c6 (.i_clk, .i_rst_n, .i_vld(v5),
        .i_data(lvl6), .o_vld(v6), .o_data(d6));

    // Serializer
    logic [4:0] nb;
    assign nb = (r_code_bits == 5'd0) ? 5'd1 :
                ((r_code_bits > 5'd16) ? 5'd16 : r_code_bits);

    logic [4:0]  r_left, n_left;
    logic [15:0] r_lvl, n_lvl;
    logic [4:0]  r_gap, n_gap;

    always_comb begin
        n_left = r_left;
        n_lvl  = r_lvl;
        if (r_left != 5'd0) n_left = r_left - 5'd1;
        if (v6) begin
            n_left = nb;
            n_lvl  = d6;
        end
        n_gap = r_gap;
        if (accept)              n_gap = nb - 5'd1;
        else if (r_gap != 5'd0)  n_gap = r_gap - 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 5'd0;
            r_gap  <= 5'd0;
        end else begin
            r_left <= n_left;
            r_gap  <= n_gap;
        end
        r_lvl <= n_lvl;
    end

    // Space requests so each word loads as the last bit leaves.
    assign busy = (r_gap != 5'd0);

    logic [4:0] sh;
    assign sh = r_left - 5'd1;
    assign o_strobe      = (r_left != 5'd0);
    assign o_bit_value   = r_lvl[sh[3:0]];
    assign o_is_last     = (r_left == 5'd1);
    assign o_level_value = r_lvl;
endmodule
